@@ rtl/core/sass_pkg.sv @@
// ----------------------------------------------------------------------------
// sass_pkg
// Shared constants for the stick angle sector selector: CORDIC sizing,
// angle encoding, arctangent table and configuration register indexes.
// ----------------------------------------------------------------------------
package sass_pkg;

  // angle result width and pipeline sizing
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_SECTORS   = 64;

  // field widths
  localparam int STICK_W   = 16;
  localparam int BAND_W    = 15;
  localparam int COUNT_W   = 7;
  localparam int SECTOR_W  = 6;
  localparam int NCLAMP_W  = $clog2(MAX_SECTORS + 1);

  // datapath width: 2^15 * sqrt(2) * 1.647 gain fits in 18 bits, keep margin
  localparam int XY_W      = 20;
  localparam int TURN_W    = 32;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = CFG_IDX_W'(1);

  localparam logic [BAND_W-1:0]  DEAD_BAND_RST    = BAND_W'(300);
  localparam logic [COUNT_W-1:0] SECTOR_COUNT_RST = COUNT_W'(16);

  // fixed turn fractions
  localparam logic [TURN_W-1:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [TURN_W-1:0] TURN_3QUARTER = 32'hC000_0000;

  // atan(2^-i) as a 32-bit fraction of a turn
  localparam int TABLE_LEN = 24;
  localparam logic [TURN_W-1:0] ATAN_TURN [0:TABLE_LEN-1] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  // accept edge to result strobe: entry stage, CORDIC stages, output stage
  localparam int LATENCY = CORDIC_STAGES + 2;

endpackage

@@ rtl/core/stick_angle_sector_select.sv @@
// ----------------------------------------------------------------------------
// stick_angle_sector_select
// Joystick X/Y sample to dead-zone flag or angular sector index, using a
// fully pipelined vectoring CORDIC atan2.
// ----------------------------------------------------------------------------
// Usage:
//   input beat: drive in_stick_x / in_stick_y and raise start; the beat is
//   taken at any edge where start is high and busy is low. busy stays low,
//   so a new sample can be taken every cycle.
//   result beat: out_valid is high for one cycle with out_in_dead_zone and
//   out_sector_index. The result of a sample passes through 18 register
//   stages: one entry stage that folds the vector into the right half
//   plane, one stage per CORDIC iteration, one stage for the sector
//   multiply. Throughput is one beat per cycle, results leave in input
//   order.
//   config: cfg_valid / cfg_ready / cfg_index / cfg_data; index 0 is
//   dead_band, index 1 is sector_count, other indexes are dropped. Write
//   only while no sample is in flight.
//   reset: synchronous rst_n low empties the pipeline and restores
//   dead_band = 300 and sector_count = 16.
//   The receiver cannot stall; every result is shown exactly once.
module stick_angle_sector_select (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sass_pkg::STICK_W-1:0]  in_stick_x,
  input  logic signed [sass_pkg::STICK_W-1:0]  in_stick_y,
  output logic                                 out_valid,
  output logic                                 out_in_dead_zone,
  output logic [sass_pkg::SECTOR_W-1:0]        out_sector_index,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sass_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sass_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int XW = sass_pkg::XY_W;
  localparam int ZW = sass_pkg::TURN_W;
  localparam int NS = sass_pkg::CORDIC_STAGES;
  localparam int AB = sass_pkg::ANGLE_BITS;
  localparam int NW = sass_pkg::NCLAMP_W;

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // configuration registers
  logic [sass_pkg::BAND_W-1:0]  dead_band_r;
  logic [sass_pkg::COUNT_W-1:0] sector_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_band_r    <= sass_pkg::DEAD_BAND_RST;
      sector_count_r <= sass_pkg::SECTOR_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sass_pkg::REG_DEAD_BAND:    dead_band_r    <= cfg_data[sass_pkg::BAND_W-1:0];
        sass_pkg::REG_SECTOR_COUNT: sector_count_r <= cfg_data[sass_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // entry: flip y, dead-zone test, fold into right half plane
  logic signed [XW-1:0] x_in, y_in, ax_in, ay_in;
  logic signed [XW-1:0] x0_nxt, y0_nxt;
  logic [ZW-1:0]        z0_nxt;
  logic                 dead_nxt;

  always_comb begin
    x_in  = XW'(in_stick_x);
    y_in  = -XW'(in_stick_y);
    ax_in = x_in[XW-1] ? -x_in : x_in;
    ay_in = y_in[XW-1] ? -y_in : y_in;
    dead_nxt = (ax_in < $signed({{(XW-sass_pkg::BAND_W){1'b0}}, dead_band_r})) &&
               (ay_in < $signed({{(XW-sass_pkg::BAND_W){1'b0}}, dead_band_r}));
    if (x_in == '0) begin
      // vertical axis: exact quarter turns, zero vector stays at 0
      x0_nxt = '0;
      y0_nxt = '0;
      if (y_in[XW-1])      z0_nxt = sass_pkg::TURN_3QUARTER;
      else if (y_in != '0) z0_nxt = sass_pkg::TURN_QUARTER;
      else                 z0_nxt = '0;
    end else if (x_in[XW-1]) begin
      x0_nxt = -x_in;
      y0_nxt = -y_in;
      z0_nxt = sass_pkg::TURN_HALF;
    end else begin
      x0_nxt = x_in;
      y0_nxt = y_in;
      z0_nxt = '0;
    end
  end

  // pipeline registers, index 0 is the entry stage
  logic                 v_r    [0:NS];
  logic                 dead_r [0:NS];
  logic signed [XW-1:0] x_r    [0:NS];
  logic signed [XW-1:0] y_r    [0:NS];
  logic [ZW-1:0]        z_r    [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= accept;
  end

  always_ff @(posedge clk) begin
    dead_r[0] <= dead_nxt;
    x_r[0]    <= x0_nxt;
    y_r[0]    <= y0_nxt;
    z_r[0]    <= z0_nxt;
  end

  // one CORDIC iteration per stage, rotation steered by the sign of y
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [XW-1:0] dx, dy, x_nxt, y_nxt;
    logic [ZW-1:0]        z_nxt;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (y_r[i][XW-1]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - sass_pkg::ATAN_TURN[i];
      end else if (y_r[i] != '0) begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + sass_pkg::ATAN_TURN[i];
      end else begin
        x_nxt = x_r[i];
        y_nxt = y_r[i];
        z_nxt = z_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else        v_r[i+1] <= v_r[i];
    end

    always_ff @(posedge clk) begin
      dead_r[i+1] <= dead_r[i];
      x_r[i+1]    <= x_nxt;
      y_r[i+1]    <= y_nxt;
      z_r[i+1]    <= z_nxt;
    end
  end

  // sector quantize: floor(angle * n / 2^ANGLE_BITS), zero in the dead zone
  logic [NW-1:0]    n_clamp;
  logic [AB-1:0]    angle;
  logic [AB+NW-1:0] prod;
  logic [sass_pkg::SECTOR_W-1:0] sector_nxt;

  always_comb begin
    if (sector_count_r == '0)
      n_clamp = NW'(1);
    else if (32'(sector_count_r) > sass_pkg::MAX_SECTORS)
      n_clamp = NW'(sass_pkg::MAX_SECTORS);
    else
      n_clamp = NW'(sector_count_r);
    angle      = z_r[NS][ZW-1 -: AB];
    prod       = (AB+NW)'(angle) * (AB+NW)'(n_clamp);
    sector_nxt = dead_r[NS] ? '0 : prod[AB +: sass_pkg::SECTOR_W];
  end

  // output stage
  logic                          out_valid_r, dead_out_r;
  logic [sass_pkg::SECTOR_W-1:0] sector_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v_r[NS];
  end

  always_ff @(posedge clk) begin
    dead_out_r   <= dead_r[NS];
    sector_out_r <= sector_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_in_dead_zone = dead_out_r;
  assign out_sector_index = sector_out_r;

  // checks
  a_dead_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_dead_zone |-> out_sector_index == '0)
    else $error("dead zone result carries a nonzero sector");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(sass_pkg::LATENCY) out_valid)
    else $error("accepted sample did not produce a result on time");

  a_entry_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> $past(accept))
    else $error("entry stage valid without an accepted beat");

  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == sass_pkg::REG_SECTOR_COUNT |=>
      sector_count_r == $past(cfg_data[sass_pkg::COUNT_W-1:0]))
    else $error("sector_count write lost");

endmodule
